// ----- hw/rtl/brem_pkg.sv -----
// shared types and constants of the rms energy meter
package brem_pkg;

    localparam int SampleBits = 16;
    localparam int MaxBlock = 4096;
    localparam int BlockSumW = 43;
    localparam int BlockCntW = 13;
    localparam int BarSumW = 52;
    localparam int BarCntW = 22;
    localparam int SpbW = 21;
    localparam int CoeffW = 16;
    localparam int LevelW = 16;
    localparam int QueueDepth = 2;
    localparam int CfgIdxW = 1;

    localparam logic [CfgIdxW-1:0] RegSamplesPerBar = 1'b0;
    localparam logic [CfgIdxW-1:0] RegSmoothCoeff = 1'b1;

    localparam logic [SpbW-1:0] SpbReset = 21'd96000;
    localparam logic [CoeffW-1:0] CoeffReset = 16'd6554;
    localparam logic [LevelW-1:0] OneQ = 16'd32768;

    typedef struct packed {
        logic [BlockSumW-1:0] sum;
        logic [BlockCntW-1:0] count;
    } blk_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BLK_RMS,
        ST_SMOOTH,
        ST_BAR_RMS,
        ST_OUT
    } back_state_t;

endpackage

// ----- hw/rtl/brem_if.sv -----
// valid/ready channel interfaces of the rms energy meter
interface brem_in_if (input logic clk);
    logic valid;
    logic ready;
    logic signed [15:0] sample;
    logic block_end;
    modport source (output valid, sample, block_end, input ready);
    modport sink (input valid, sample, block_end, output ready);
endinterface

interface brem_out_if (input logic clk);
    logic valid;
    logic ready;
    logic [15:0] level;
    logic [15:0] bar_level;
    logic bar_done;
    modport source (output valid, level, bar_level, bar_done, input ready);
    modport sink (input valid, level, bar_level, bar_done, output ready);
endinterface

interface brem_cfg_if (input logic clk);
    logic valid;
    logic ready;
    logic [0:0] index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/block_rms_energy_meter.sv -----
// top level of the block rms energy meter
// Samples are taken one per cycle by the front end while the queue is not full; the front end
// squares and sums them, and a block-end request passes through a two-entry queue to the back
// end. Per block the back end runs a shared iterative rms unit (restoring divide, then square
// root), once for the block and once more when a bar completes. Samples keep flowing while
// fewer than two finished blocks wait in the queue.
module block_rms_energy_meter (
    input  logic clk,
    input  logic rst_n,
    brem_in_if.sink in_ch,
    brem_out_if.source out_ch,
    brem_cfg_if.sink cfg
);
    import brem_pkg::*;

    logic [SpbW-1:0] spb_reg;
    logic [CoeffW-1:0] coeff_reg;
    logic f_valid, f_ready, q_valid, q_ready;
    blk_req_t f_req, q_req;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spb_reg <= SpbReset;
            coeff_reg <= CoeffReset;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                RegSamplesPerBar: spb_reg <= cfg.data[SpbW-1:0];
                RegSmoothCoeff:   coeff_reg <= cfg.data[CoeffW-1:0];
                default: ;
            endcase
        end
    end

    brem_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .sample(in_ch.sample), .block_end(in_ch.block_end),
        .req_valid(f_valid), .req_ready(f_ready), .req(f_req)
    );

    brem_queue u_queue (
        .clk(clk), .rst_n(rst_n), .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_req),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_req)
    );

    brem_back u_back (
        .clk(clk), .rst_n(rst_n), .samples_per_bar(spb_reg), .smooth_coeff(coeff_reg),
        .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .level(out_ch.level),
        .bar_level(out_ch.bar_level), .bar_done(out_ch.bar_done)
    );
endmodule

// ----- hw/rtl/brem_front.sv -----
// front end: squares samples and accumulates block sums
module brem_front (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic signed [15:0] sample,
    input  logic block_end,
    output logic req_valid,
    input  logic req_ready,
    output brem_pkg::blk_req_t req
);
    import brem_pkg::*;

    logic [BlockSumW-1:0] sum_reg, sum_next;
    logic [BlockCntW-1:0] cnt_reg, cnt_next;
    logic [15:0] mag;
    logic [31:0] sq;
    logic fire, ends;

    assign mag = sample[15] ? 16'(-sample) : 16'(sample);
    assign sq = mag * mag;
    assign in_ready = req_ready;
    assign fire = in_valid && in_ready;
    assign sum_next = sum_reg + BlockSumW'(sq);
    assign cnt_next = cnt_reg + 1'b1;
    assign ends = block_end || (cnt_next == BlockCntW'(MaxBlock));
    assign req_valid = fire && ends;
    assign req.sum = sum_next;
    assign req.count = cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else if (fire)
        begin
            sum_reg <= ends ? '0 : sum_next;
            cnt_reg <= ends ? '0 : cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < BlockCntW'(MaxBlock)) else $error("block count overrun");
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid |=> cnt_reg == '0) else $error("block not cleared");
    a_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid |-> req_ready) else $error("request while queue full");
`endif
endmodule

// ----- hw/rtl/brem_queue.sv -----
// short fifo between front end and back end
module brem_queue (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  brem_pkg::blk_req_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output brem_pkg::blk_req_t rd_data
);
    import brem_pkg::*;

    blk_req_t mem [QueueDepth];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign wr_ready = cnt_reg != 2'(QueueDepth);
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_valid && wr_ready)
            mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_valid && wr_ready)
                wp_reg <= ~wp_reg;
            if (rd_valid && rd_ready)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
        end
    end

`ifndef SYNTHESIS
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(QueueDepth)) else $error("queue overflow");
    a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0 || cnt_reg == 2'(QueueDepth)) == (wp_reg == rp_reg))
        else $error("queue pointers out of step");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid && !rd_ready && !wr_valid |=> rd_valid) else $error("queue lost entry");
`endif
endmodule

// ----- hw/rtl/brem_rms.sv -----
// iterative rms unit: restoring divide then bitwise square root
module brem_rms (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic [brem_pkg::BarSumW-1:0] sum,
    input  logic [brem_pkg::BarCntW-1:0] count,
    output logic done,
    output logic [brem_pkg::LevelW-1:0] rms
);
    import brem_pkg::*;

    typedef enum logic [1:0] {R_IDLE, R_DIV, R_SQRT, R_DONE} rms_state_t;

    rms_state_t st_reg;
    logic [5:0] step_reg;
    logic [BarSumW-1:0] q_reg;
    logic [BarCntW:0] rem_reg;
    logic [BarCntW-1:0] d_reg;
    logic [BarSumW+1:0] v_reg;
    logic [BarSumW+1:0] res_reg;
    logic [BarSumW+1:0] bit_reg;
    logic [BarCntW:0] rs;
    logic [BarSumW+1:0] trial;

    assign rs = {rem_reg[BarCntW-1:0], q_reg[BarSumW-1]};
    assign trial = res_reg + bit_reg;
    assign done = st_reg == R_DONE;
    assign rms = (res_reg > (BarSumW+2)'(OneQ)) ? OneQ : res_reg[LevelW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= R_IDLE;
            step_reg <= '0;
            q_reg <= '0;
            rem_reg <= '0;
            d_reg <= '0;
            v_reg <= '0;
            res_reg <= '0;
            bit_reg <= '0;
        end
        else
        begin
            unique case (st_reg)
                R_IDLE:
                begin
                    if (start)
                    begin
                        q_reg <= sum;
                        d_reg <= count;
                        rem_reg <= '0;
                        step_reg <= 6'(BarSumW);
                        res_reg <= '0;
                        st_reg <= (count == '0) ? R_DONE : R_DIV;
                    end
                end
                R_DIV:
                begin
                    if (rs >= {1'b0, d_reg})
                    begin
                        rem_reg <= rs - {1'b0, d_reg};
                        q_reg <= {q_reg[BarSumW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rs;
                        q_reg <= {q_reg[BarSumW-2:0], 1'b0};
                    end
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == 6'd1)
                    begin
                        st_reg <= R_SQRT;
                        bit_reg <= (BarSumW+2)'(1) << BarSumW;
                        step_reg <= 6'((BarSumW+2)/2);
                    end
                end
                R_SQRT:
                begin
                    if (step_reg == 6'((BarSumW+2)/2))
                        v_reg <= (BarSumW+2)'(q_reg);
                    else if (v_reg >= trial)
                    begin
                        v_reg <= v_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                        res_reg <= res_reg >> 1;
                    if (step_reg != 6'((BarSumW+2)/2))
                        bit_reg <= bit_reg >> 2;
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == 6'd0)
                        st_reg <= R_DONE;
                end
                R_DONE:
                    st_reg <= R_IDLE;
                default:
                    st_reg <= R_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");
    a_div: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == R_DIV |-> rem_reg < {1'b0, d_reg}) else $error("remainder too large");
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == R_IDLE && start && count == '0 |=> rms == '0) else $error("zero count");
`endif
endmodule

// ----- hw/rtl/brem_back.sv -----
// back end: block rms, smoothing, bar energy and result register
module brem_back (
    input  logic clk,
    input  logic rst_n,
    input  logic [brem_pkg::SpbW-1:0] samples_per_bar,
    input  logic [brem_pkg::CoeffW-1:0] smooth_coeff,
    input  logic req_valid,
    output logic req_ready,
    input  brem_pkg::blk_req_t req,
    output logic out_valid,
    input  logic out_ready,
    output logic [15:0] level,
    output logic [15:0] bar_level,
    output logic bar_done
);
    import brem_pkg::*;

    back_state_t st_reg, st_next;
    logic [LevelW-1:0] smooth_reg, blk_rms_reg;
    logic [LevelW-1:0] bar_reg;
    logic [BarSumW-1:0] bsum_reg;
    logic [BarCntW-1:0] bcnt_reg;
    logic done_reg;
    logic ov_reg;
    logic [LevelW-1:0] o_level_reg, o_bar_reg;
    logic o_done_reg;
    logic rms_start, rms_done;
    logic [BarSumW-1:0] rms_sum;
    logic [BarCntW-1:0] rms_cnt;
    logic [LevelW-1:0] rms_val;
    logic [BarSumW:0] bsum_add;
    logic [BarCntW:0] bcnt_add;
    logic [BarSumW-1:0] bsum_sat;
    logic [BarCntW-1:0] bcnt_sat;
    logic signed [LevelW+1:0] diff;
    logic signed [LevelW+CoeffW+2:0] prod;
    logic signed [LevelW+2:0] stp;
    logic bar_hit;

    assign bsum_add = {1'b0, bsum_reg} + (BarSumW+1)'(req.sum);
    assign bcnt_add = {1'b0, bcnt_reg} + (BarCntW+1)'(req.count);
    assign bsum_sat = bsum_add[BarSumW] ? '1 : bsum_add[BarSumW-1:0];
    assign bcnt_sat = bcnt_add[BarCntW] ? '1 : bcnt_add[BarCntW-1:0];
    assign bar_hit = samples_per_bar != '0 && bcnt_reg >= BarCntW'(samples_per_bar);
    assign diff = $signed({2'b00, blk_rms_reg}) - $signed({2'b00, smooth_reg});
    assign prod = $signed({1'b0, smooth_coeff}) * diff;
    assign stp = (LevelW+3)'(prod >>> 16);

    assign rms_start = (st_reg == ST_IDLE && req_valid && !ov_reg)
                       || (st_reg == ST_SMOOTH && bar_hit);
    assign rms_sum = (st_reg == ST_IDLE) ? BarSumW'(req.sum) : bsum_reg;
    assign rms_cnt = (st_reg == ST_IDLE) ? BarCntW'(req.count) : bcnt_reg;

    brem_rms u_rms (
        .clk(clk), .rst_n(rst_n), .start(rms_start), .sum(rms_sum),
        .count(rms_cnt), .done(rms_done), .rms(rms_val)
    );

    assign req_ready = st_reg == ST_IDLE && !ov_reg;
    assign out_valid = ov_reg;
    assign level = o_level_reg;
    assign bar_level = o_bar_reg;
    assign bar_done = o_done_reg;

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:    if (req_valid && !ov_reg) st_next = ST_BLK_RMS;
            ST_BLK_RMS: if (rms_done) st_next = ST_SMOOTH;
            ST_SMOOTH:  st_next = bar_hit ? ST_BAR_RMS : ST_OUT;
            ST_BAR_RMS: if (rms_done) st_next = ST_OUT;
            ST_OUT:     st_next = ST_IDLE;
            default:    st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= ST_IDLE;
        else
            st_reg <= st_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smooth_reg <= '0;
            blk_rms_reg <= '0;
            bar_reg <= '0;
            bsum_reg <= '0;
            bcnt_reg <= '0;
            done_reg <= 1'b0;
            ov_reg <= 1'b0;
            o_level_reg <= '0;
            o_bar_reg <= '0;
            o_done_reg <= 1'b0;
        end
        else
        begin
            if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            unique case (st_reg)
                ST_IDLE:
                begin
                    if (req_valid && !ov_reg)
                    begin
                        bsum_reg <= bsum_sat;
                        bcnt_reg <= bcnt_sat;
                    end
                    done_reg <= 1'b0;
                end
                ST_BLK_RMS:
                    if (rms_done) blk_rms_reg <= rms_val;
                ST_SMOOTH:
                    smooth_reg <= LevelW'($signed({2'b00, smooth_reg}) + stp);
                ST_BAR_RMS:
                begin
                    if (rms_done)
                    begin
                        bar_reg <= rms_val;
                        done_reg <= 1'b1;
                        bsum_reg <= '0;
                        bcnt_reg <= bcnt_reg - BarCntW'(samples_per_bar);
                    end
                end
                ST_OUT:
                begin
                    ov_reg <= 1'b1;
                    o_level_reg <= smooth_reg;
                    o_bar_reg <= bar_reg;
                    o_done_reg <= done_reg;
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_lvl: assert property (@(posedge clk) disable iff (!rst_n)
        smooth_reg <= OneQ) else $error("level above one");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(level)) else $error("result changed");
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == ST_OUT |-> !ov_reg) else $error("result overwritten");
`endif
endmodule
